>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while in reset.
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/rie_pkg.sv
package rie_pkg;

    // Default block size in bytes
    localparam int BLOCK_BYTES_DEF = 256;

    localparam int KEY_W   = 31;
    localparam int BLOCK_W = 16;
    localparam int OFS_W   = 8;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    // Marker bytes
    localparam logic [7:0] CHAR_PIPE   = 8'h7C;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   record_key;
        logic [BLOCK_W-1:0] block_number;
        logic [OFS_W-1:0]   byte_offset;
    } out_item_t;

endpackage

>>> hw/rtl/record_index_extractor.sv
// Record index extractor.
// The item channel (item_valid, item_stall, item) takes one byte of a block
// file per transaction; is_final marks the last byte of the file. The result
// channel (result_valid, result_stall, result) gives key, block number and
// offset of the first key byte for each live record, one transaction each.
// A byte is taken every cycle while the result side keeps up: throughput is
// one byte per cycle, set by the single parser state update per byte.
// A result appears on the port in the cycle after its flag byte is
// accepted, held in the output register.
// When the receiver stalls, the pending result holds and item_stall rises
// only while that register is full and stalled.
// Reset clears the parser, the block and offset counters and the output
// valid; after the final byte the parser and counters return to their reset values.
module record_index_extractor
    import rie_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic      step;
    logic      res_valid;
    out_item_t res;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // Stall input only while a stalled result occupies the output register
    assign item_stall = out_valid_reg && result_stall;
    assign step       = item_valid && !item_stall;

    rie_scanner #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_scanner (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (item),
        .res_valid(res_valid),
        .res      (res)
    );

    // Output valid: load when empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !result_stall)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

>>> hw/rtl/rie_scanner.sv
`include "assert_macros.svh"

module rie_scanner
    import rie_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res
);

    localparam int OFF_W = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;
    localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(BLOCK_BYTES - 1);

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_KEY,
        PH_FLAG
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               ended_reg, ended_next;
    logic [BLOCK_W-1:0] sblk_reg, sblk_next;
    logic [OFS_W-1:0]   soff_reg, soff_next;
    logic [BLOCK_W-1:0] cblk_reg, cblk_next;
    logic [OFF_W-1:0]   coff_reg, coff_next;

    logic [OFF_W+OFS_W-1:0] noff_ext;
    logic [KEY_W+3:0]       prod;
    logic [3:0]             digit;
    logic                   is_digit;
    logic [7:0]             byte_val;

    assign byte_val = item.data_byte;

    // Position of the byte after this one
    always_comb
    begin
        if (coff_reg == LAST_OFF)
        begin
            coff_next = '0;
            cblk_next = cblk_reg + BLOCK_W'(1);
        end
        else
        begin
            coff_next = coff_reg + OFF_W'(1);
            cblk_next = cblk_reg;
        end
        noff_ext = {{OFS_W{1'b0}}, coff_next};
    end

    // Decimal accumulate: key * 10 + digit, saturated
    always_comb
    begin
        is_digit = (byte_val >= CHAR_ZERO) && (byte_val <= CHAR_NINE);
        digit    = 4'(byte_val - CHAR_ZERO);
        prod     = (KEY_W+4)'({key_reg, 3'b000}) + (KEY_W+4)'({key_reg, 1'b0})
                 + (KEY_W+4)'(digit);
    end

    // Record parser
    always_comb
    begin
        phase_next = phase_reg;
        key_next   = key_reg;
        ended_next = ended_reg;
        sblk_next  = sblk_reg;
        soff_next  = soff_reg;
        res_valid  = 1'b0;
        case (phase_reg)
            PH_SEEK:
            begin
                if (byte_val == CHAR_PIPE)
                begin
                    phase_next = PH_KEY;
                    key_next   = '0;
                    ended_next = 1'b0;
                    sblk_next  = cblk_next;
                    soff_next  = noff_ext[OFS_W-1:0];
                end
            end
            PH_KEY:
            begin
                if (byte_val == CHAR_DOLLAR)
                begin
                    phase_next = PH_FLAG;
                end
                else if (!ended_reg && is_digit)
                begin
                    key_next = (prod[KEY_W+3:KEY_W] != 4'd0) ? KEY_MAX : prod[KEY_W-1:0];
                end
                else
                begin
                    ended_next = 1'b1;
                end
            end
            PH_FLAG:
            begin
                res_valid = step && (byte_val != CHAR_ONE);
                if (byte_val == CHAR_PIPE)
                begin
                    phase_next = PH_KEY;
                    key_next   = '0;
                    ended_next = 1'b0;
                    sblk_next  = cblk_next;
                    soff_next  = noff_ext[OFS_W-1:0];
                end
                else
                begin
                    phase_next = PH_SEEK;
                end
            end
            default:
            begin
                phase_next = PH_SEEK;
            end
        endcase
    end

    assign res.record_key   = key_reg;
    assign res.block_number = sblk_reg;
    assign res.byte_offset  = soff_reg;

    // Advance state on each transaction; the final byte returns all state to its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            key_reg   <= '0;
            ended_reg <= 1'b0;
            sblk_reg  <= '0;
            soff_reg  <= '0;
            cblk_reg  <= '0;
            coff_reg  <= '0;
        end
        else if (step)
        begin
            if (item.is_final)
            begin
                phase_reg <= PH_SEEK;
                key_reg   <= '0;
                ended_reg <= 1'b0;
                sblk_reg  <= '0;
                soff_reg  <= '0;
                cblk_reg  <= '0;
                coff_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                key_reg   <= key_next;
                ended_reg <= ended_next;
                sblk_reg  <= sblk_next;
                soff_reg  <= soff_next;
                cblk_reg  <= cblk_next;
                coff_reg  <= coff_next;
            end
        end
    end

    `ASSERT_NXT(a_final_clears, clk, rst_n, step && item.is_final, (phase_reg == PH_SEEK) && (cblk_reg == '0) && (coff_reg == '0))
    `ASSERT_IMP(a_res_from_flag, clk, rst_n, res_valid, step && (phase_reg == PH_FLAG))
    `ASSERT_IMP(a_offset_in_block, clk, rst_n, 1'b1, coff_reg <= LAST_OFF)

endmodule
